@@ src/htu_pkg.sv @@
// ----------------------------------------------------------------------------
// htu_pkg
// Shared types, constants and helpers of the hex text UTF-8 checker.
// ----------------------------------------------------------------------------
package htu_pkg;

	// end-of-text verdict codes
	typedef enum logic [1:0] {
		VERDICT_GOOD     = 2'd0,
		VERDICT_ODD_LEN  = 2'd1,
		VERDICT_BAD_HEX  = 2'd2,
		VERDICT_BAD_UTF8 = 2'd3
	} verdict_t;

	// decoded hex character
	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_digit_t;

	// lead byte ranges
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;
	localparam logic [7:0] ASCII_MAX = 8'h7F;

	// smallest legal code point per sequence length
	localparam logic [16:0] MIN_CP2 = 17'h00080;
	localparam logic [16:0] MIN_CP3 = 17'h00800;
	localparam logic [16:0] MIN_CP4 = 17'h10000;

	// code point limits
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DFFF;
	localparam logic [20:0] CP_MAX  = 21'h10FFFF;

	// continuation payload mask
	localparam logic [7:0] CONT_MASK = 8'h3F;

	// map an ASCII character to its hex value
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok  = 1'b1;
		d.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.nib = 4'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.nib = 4'(c - 8'h61 + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

@@ src/htu_if.sv @@
// ----------------------------------------------------------------------------
// htu_if
// Valid/ready channels of the hex text UTF-8 checker: characters in,
// decoded bytes and verdicts out.
// ----------------------------------------------------------------------------
interface htu_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface htu_result_if;
	logic              valid;
	logic              ready;
	logic              byte_valid;
	logic [7:0]        data_byte;
	logic              end_of_text;
	htu_pkg::verdict_t verdict;

	modport source (output valid, output byte_valid, output data_byte,
		output end_of_text, output verdict, input ready);
	modport sink   (input valid, input byte_valid, input data_byte,
		input end_of_text, input verdict, output ready);
endinterface

@@ src/hex_text_utf8_checker.sv @@
// ----------------------------------------------------------------------------
// hex_text_utf8_checker
// Pairs hex digits into bytes, checks the byte stream as strict UTF-8 and
// reports a verdict on the last character of each text.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, sustained while the result side
// takes each result as it comes. A character goes into an input register, the
// hex pairing and UTF-8 check work on it in one pass of compare and shift
// logic, and the result lands in an output register. A result held on the
// output stalls the input only when the character waiting in the input
// register would make another result. Only the second digit of a pair or the
// last character makes a result; other characters just update the decoder
// state. When the verdict on end_of_text is not good, the bytes delivered for
// that text are to be thrown away. The state clears itself after each last
// character, ready for the next text.
module hex_text_utf8_checker (
	input  logic         clk,
	input  logic         arst_n,
	htu_char_if.sink     chars,
	htu_result_if.source results
);
	import htu_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// decoder state
	logic        second_due_q;
	logic [3:0]  high_nib_q;
	logic        hex_fail_q;
	logic        utf_fail_q;
	logic [1:0]  cont_left_q;
	logic [16:0] least_cp_q;
	logic [20:0] cp_acc_q;

	// next state
	logic        second_due_d;
	logic [3:0]  high_nib_d;
	logic        hex_fail_d;
	logic        utf_fail_d;
	logic [1:0]  cont_left_d;
	logic [16:0] least_cp_d;
	logic [20:0] cp_acc_d;

	// result register
	logic       res_valid_q;
	logic       byte_valid_q;
	logic [7:0] data_byte_q;
	logic       end_q;
	verdict_t   verdict_q;

	hex_digit_t digit;
	logic       emit;
	logic [7:0] data;
	logic [20:0] cp_shift;
	verdict_t   verdict_d;
	logic       has_result;
	logic       advance;

	// pipeline flow
	assign has_result  = emit || last_s1;
	assign advance     = valid_s1 && (!has_result || !res_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	// hex pairing and UTF-8 check
	always_comb begin
		digit        = hex_decode(char_s1);
		second_due_d = !second_due_q;
		high_nib_d   = high_nib_q;
		hex_fail_d   = hex_fail_q || !digit.ok;
		utf_fail_d   = utf_fail_q;
		cont_left_d  = cont_left_q;
		least_cp_d   = least_cp_q;
		cp_acc_d     = cp_acc_q;
		emit         = 1'b0;
		data         = {high_nib_q, digit.nib};
		cp_shift     = {cp_acc_q[14:0], data[5:0]};
		if (!second_due_q) begin
			high_nib_d = digit.nib;
		end else begin
			emit = !hex_fail_d;
		end

		// feed the decoded byte to the validator
		if (emit && !utf_fail_q) begin
			if (cont_left_q == 2'd0) begin
				if (data <= ASCII_MAX) begin
					utf_fail_d = 1'b0;
				end else if (data >= LEAD2_MIN && data <= LEAD2_MAX) begin
					cont_left_d = 2'd1;
					least_cp_d  = MIN_CP2;
					cp_acc_d    = {16'd0, data[4:0]};
				end else if (data >= LEAD3_MIN && data <= LEAD3_MAX) begin
					cont_left_d = 2'd2;
					least_cp_d  = MIN_CP3;
					cp_acc_d    = {17'd0, data[3:0]};
				end else if (data >= LEAD4_MIN && data <= LEAD4_MAX) begin
					cont_left_d = 2'd3;
					least_cp_d  = MIN_CP4;
					cp_acc_d    = {18'd0, data[2:0]};
				end else begin
					utf_fail_d = 1'b1;
				end
			end else if ((data & ~CONT_MASK) != 8'h80) begin
				utf_fail_d = 1'b1;
			end else begin
				cp_acc_d    = cp_shift;
				cont_left_d = 2'(cont_left_q - 2'd1);
				// range check on the finished code point
				if (cont_left_q == 2'd1 &&
					(cp_shift < {4'd0, least_cp_q} ||
					(cp_shift >= SURR_LO && cp_shift <= SURR_HI) ||
					cp_shift > CP_MAX)) begin
					utf_fail_d = 1'b1;
				end
			end
		end

		// verdict, odd length first
		if (second_due_d) begin
			verdict_d = VERDICT_ODD_LEN;
		end else if (hex_fail_d) begin
			verdict_d = VERDICT_BAD_HEX;
		end else if (utf_fail_d || cont_left_d != 2'd0) begin
			verdict_d = VERDICT_BAD_UTF8;
		end else begin
			verdict_d = VERDICT_GOOD;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.last_char;
		end
	end

	// decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_due_q <= 1'b0;
			high_nib_q   <= 4'd0;
			hex_fail_q   <= 1'b0;
			utf_fail_q   <= 1'b0;
			cont_left_q  <= 2'd0;
			least_cp_q   <= 17'd0;
			cp_acc_q     <= 21'd0;
		end else if (advance) begin
			if (last_s1) begin
				second_due_q <= 1'b0;
				high_nib_q   <= 4'd0;
				hex_fail_q   <= 1'b0;
				utf_fail_q   <= 1'b0;
				cont_left_q  <= 2'd0;
				least_cp_q   <= 17'd0;
				cp_acc_q     <= 21'd0;
			end else begin
				second_due_q <= second_due_d;
				high_nib_q   <= high_nib_d;
				hex_fail_q   <= hex_fail_d;
				utf_fail_q   <= utf_fail_d;
				cont_left_q  <= cont_left_d;
				least_cp_q   <= least_cp_d;
				cp_acc_q     <= cp_acc_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			byte_valid_q <= emit;
			data_byte_q  <= emit ? data : 8'd0;
			end_q        <= last_s1;
			verdict_q    <= last_s1 ? verdict_d : VERDICT_GOOD;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.byte_valid  = byte_valid_q;
	assign results.data_byte   = data_byte_q;
	assign results.end_of_text = end_q;
	assign results.verdict     = verdict_q;

endmodule

@@ src/htu_checker.sv @@
// ----------------------------------------------------------------------------
// htu_checker
// Port-level checks on the result channel of the hex text UTF-8 checker.
// ----------------------------------------------------------------------------
module htu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic              byte_valid,
	input logic [7:0]        data_byte,
	input logic              end_of_text,
	input htu_pkg::verdict_t verdict
);
	import htu_pkg::*;

	// a stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(data_byte) &&
		$stable(byte_valid) && $stable(end_of_text) && $stable(verdict))
		else $error("result changed while stalled");

	// every result carries a byte or an end of text
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> byte_valid || end_of_text)
		else $error("empty result transaction");

	// verdict only reported at end of text
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !end_of_text |-> verdict == VERDICT_GOOD)
		else $error("verdict outside end of text");

	// no byte when byte_valid is low
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !byte_valid |-> data_byte == 8'd0)
		else $error("data without byte_valid");

endmodule

bind hex_text_utf8_checker htu_checker u_htu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.byte_valid  (results.byte_valid),
	.data_byte   (results.data_byte),
	.end_of_text (results.end_of_text),
	.verdict     (results.verdict)
);
